/* src/gsps_pkg.sv */
// Package for the Gauss-Seidel Poisson sweep unit: widths, opcodes, states
// and the stencil helper. No dependencies.
`timescale 1ns / 1ps
package gsps_pkg;
   localparam int ValueWidth  = 48;
   localparam int ChangeWidth = ValueWidth - 1;
   localparam int IdxWidth    = 5;
   localparam int AddrWidth   = 2 * IdxWidth;
   localparam int SweepWidth  = 16;
   localparam int CsrWidth    = 47;
   localparam int CsrIdxWidth = 2;
   localparam logic [IdxWidth-1:0] MaxIntervals = 5'd31;

   typedef logic signed [ValueWidth-1:0] value_type;
   typedef logic [ChangeWidth-1:0]       change_type;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_SOLVE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_GRID      = 2'd0,
      CSR_SWEEPS    = 2'd1,
      CSR_THRESHOLD = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP_START,
      ST_FETCH_C,
      ST_FETCH_L,
      ST_FETCH_R,
      ST_FETCH_U,
      ST_FETCH_D,
      ST_ACCUM,
      ST_WRITE,
      ST_SWEEP_END,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       add;
      value_type  operand;
   } acc_ctrl_type;
endpackage

/* src/gsps_if.sv */
// Valid/ready channel interfaces for the sweep unit.
// Depends on gsps_pkg.
`timescale 1ns / 1ps
interface gsps_req_if;
   import gsps_pkg::*;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_opcode;
   logic [IdxWidth-1:0] req_row;
   logic [IdxWidth-1:0] req_col;
   value_type           req_init_value;
   value_type           req_rhs_scaled;
   modport source (output req_valid, req_opcode, req_row, req_col, req_init_value,
                   req_rhs_scaled, input req_ready);
   modport sink (input req_valid, req_opcode, req_row, req_col, req_init_value,
                 req_rhs_scaled, output req_ready);
endinterface

interface gsps_rsp_if;
   import gsps_pkg::*;
   logic                  rsp_valid;
   logic                  rsp_ready;
   value_type             rsp_value_out;
   logic [SweepWidth-1:0] rsp_sweeps_done;
   change_type            rsp_last_change;
   logic                  rsp_converged;
   modport source (output rsp_valid, rsp_value_out, rsp_sweeps_done, rsp_last_change,
                   rsp_converged, input rsp_ready);
   modport sink (input rsp_valid, rsp_value_out, rsp_sweeps_done, rsp_last_change,
                 rsp_converged, output rsp_ready);
endinterface

/* src/gsps_accum.sv */
// Shared stencil accumulator: sums floor quarters and low-bit remainders of
// one term a cycle, then rounds and saturates. Depends on gsps_pkg.
`timescale 1ns / 1ps
module gsps_accum (
   input  logic                  clock,
   input  gsps_pkg::acc_ctrl_type ctrl,
   output gsps_pkg::value_type   result
);
   import gsps_pkg::*;

   // Floor quarters of five terms fit in ValueWidth+1 bits; remainders < 16.
   logic signed [ValueWidth:0] sum_ff, sum_in;
   logic [3:0]                 rem_ff, rem_in;
   logic signed [ValueWidth:0] total;
   logic signed [ValueWidth:0] vmax, vmin;

   always_comb begin
      sum_in = sum_ff;
      rem_in = rem_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         rem_in = '0;
      end else if (ctrl.add) begin
         sum_in = sum_ff + (ValueWidth+1)'(ctrl.operand >>> 2);
         rem_in = rem_ff + {2'b00, ctrl.operand[1:0]};
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      vmax  = {2'b00, {(ValueWidth-1){1'b1}}};
      vmin  = {2'b11, {(ValueWidth-1){1'b0}}};
      total = sum_ff + {{(ValueWidth-1){1'b0}}, rem_ff[3:2]};
      if (total > vmax)      result = vmax[ValueWidth-1:0];
      else if (total < vmin) result = vmin[ValueWidth-1:0];
      else                   result = total[ValueWidth-1:0];
   end
endmodule

/* src/gauss_seidel_poisson_sweep_unit.sv */
// Gauss-Seidel Poisson sweep unit: top level with sequencer and grid memories.
// Depends on gsps_pkg, gsps_if and gsps_accum.
`timescale 1ns / 1ps
// Operation. A load is written into both memories when it is accepted, so loads
// stream back to back. A read is accepted, waits in ST_READ for the registered
// memory read, and moves the value into the output register in ST_RESULT. A
// solve walks every interior point column by column. Each point uses the single
// grid memory read port and the shared stencil accumulator: one center fetch,
// four neighbor fetches, the last add and the write. A sweep visits no points
// when n is below 2. A solve has an accept step, up to max_sweeps sweeps and
// a result step; with a zero sweep limit it goes straight from accept to the
// result step, ST_RESULT, without any sweep. The unit holds req_ready
// low while it works on a read or a solve. A result that waits in the output
// register does not block loads; a read or solve that finishes while that
// register is still full holds in its last step until the register drains.
// The memories are not cleared: read only points that were loaded.
// Configure only while idle.
module gauss_seidel_poisson_sweep_unit (
   input  logic                           clock,
   input  logic                           reset,
   gsps_req_if.sink                       req,
   gsps_rsp_if.source                     rsp,
   input  logic                           csr_write_enable,
   input  logic [gsps_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [gsps_pkg::CsrWidth-1:0]  csr_write_data
);
   import gsps_pkg::*;

   // configuration registers
   logic [IdxWidth-1:0]   grid_ff;
   logic [SweepWidth-1:0] max_sweeps_ff;
   change_type            thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff       <= MaxIntervals;
         max_sweeps_ff <= 16'd1000;
         thresh_ff     <= 47'd1759;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID:      grid_ff       <= csr_write_data[IdxWidth-1:0];
            CSR_SWEEPS:    max_sweeps_ff <= csr_write_data[SweepWidth-1:0];
            CSR_THRESHOLD: thresh_ff     <= csr_write_data[ChangeWidth-1:0];
            CSR_UNUSED:    ;
            default:       ;
         endcase
      end
   end

   // memories: one read port each, registered data
   value_type grid_mem [0:(1<<AddrWidth)-1];
   value_type rhs_mem  [0:(1<<AddrWidth)-1];
   logic [AddrWidth-1:0] rd_addr, wr_addr;
   logic                 grid_we, rhs_we;
   value_type            grid_wdata, grid_rdata_ff, rhs_rdata_ff;

   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[wr_addr] <= grid_wdata;
      if (rhs_we)  rhs_mem[wr_addr]  <= req.req_rhs_scaled;
      grid_rdata_ff <= grid_mem[rd_addr];
      rhs_rdata_ff  <= rhs_mem[rd_addr];
   end

   // sequencer registers
   state_type             state_ff, state_in;
   logic [IdxWidth-1:0]   row_ff, row_in, col_ff, col_in, n_ff, n_in;
   logic [SweepWidth-1:0] sweeps_ff, sweeps_in;
   change_type            change_ff, change_in;
   value_type             old_ff, old_in;
   logic                  is_read_ff, is_read_in;
   logic [SweepWidth-1:0] stat_sweeps_ff, stat_sweeps_in;
   change_type            stat_change_ff, stat_change_in;
   logic                  stat_conv_ff, stat_conv_in;

   // output register: a full snapshot of one result transaction
   logic                  rsp_valid_ff, rsp_valid_in;
   value_type             rsp_value_ff, rsp_value_in;
   logic [SweepWidth-1:0] rsp_sweeps_ff, rsp_sweeps_in;
   change_type            rsp_change_ff, rsp_change_in;
   logic                  rsp_conv_ff, rsp_conv_in;

   acc_ctrl_type acc_ctrl;
   value_type    stencil_value;

   gsps_accum u_accum (
      .clock  (clock),
      .ctrl   (acc_ctrl),
      .result (stencil_value)
   );

   logic                       ready;
   logic                       accept;
   logic [AddrWidth-1:0]       point;
   logic signed [ValueWidth:0] diff;
   logic [ValueWidth:0]        mag;
   change_type                 delta;

   assign ready         = (state_ff == ST_IDLE);
   assign req.req_ready = ready;
   assign accept        = req.req_valid && ready;
   assign point         = {row_ff, col_ff};

   // saturated magnitude of the change at the current point
   always_comb begin
      diff  = (ValueWidth+1)'(stencil_value) - (ValueWidth+1)'(old_ff);
      mag   = diff[ValueWidth] ? (ValueWidth+1)'(-diff) : (ValueWidth+1)'(diff);
      delta = (mag > {2'b00, {(ChangeWidth){1'b1}}}) ? {ChangeWidth{1'b1}}
                                                      : mag[ChangeWidth-1:0];
   end

   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      n_in           = n_ff;
      sweeps_in      = sweeps_ff;
      change_in      = change_ff;
      old_in         = old_ff;
      is_read_in     = is_read_ff;
      stat_sweeps_in = stat_sweeps_ff;
      stat_change_in = stat_change_ff;
      stat_conv_in   = stat_conv_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_sweeps_in  = rsp_sweeps_ff;
      rsp_change_in  = rsp_change_ff;
      rsp_conv_in    = rsp_conv_ff;
      rd_addr        = point;
      wr_addr        = point;
      grid_we        = 1'b0;
      rhs_we         = 1'b0;
      grid_wdata     = stencil_value;
      acc_ctrl       = '{clear: 1'b0, add: 1'b0, operand: grid_rdata_ff};

      unique case (state_ff)
         ST_IDLE: begin
            wr_addr = {req.req_row, req.req_col};
            if (accept) begin
               row_in = req.req_row;
               col_in = req.req_col;
               unique case (opcode_type'(req.req_opcode))
                  OP_LOAD: begin
                     grid_we    = 1'b1;
                     rhs_we     = 1'b1;
                     grid_wdata = req.req_init_value;
                  end
                  OP_SOLVE: begin
                     // the register width already bounds n at the grid maximum
                     n_in           = grid_ff;
                     sweeps_in      = '0;
                     change_in      = '0;
                     is_read_in     = 1'b0;
                     stat_sweeps_in = '0;
                     stat_change_in = '0;
                     stat_conv_in   = 1'b0;
                     state_in = (max_sweeps_ff == '0) ? ST_RESULT : ST_SWEEP_START;
                  end
                  OP_READ: begin
                     is_read_in = 1'b1;
                     state_in   = ST_READ;
                  end
                  OP_NONE: ;
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            // hold the address in ST_READ for the registered read
            state_in = ST_RESULT;
         end
         ST_SWEEP_START: begin
            change_in = '0;
            row_in    = 5'd1;
            col_in    = 5'd1;
            state_in  = (n_ff < 5'd2) ? ST_SWEEP_END : ST_FETCH_C;
         end
         ST_FETCH_C: begin
            acc_ctrl.clear = 1'b1;
            rd_addr  = point;
            state_in = ST_FETCH_L;
         end
         ST_FETCH_L: begin
            // center value and rhs arrive now
            old_in           = grid_rdata_ff;
            acc_ctrl.add     = 1'b1;
            acc_ctrl.operand = rhs_rdata_ff;
            rd_addr  = {row_ff, col_ff - 5'd1};
            state_in = ST_FETCH_R;
         end
         ST_FETCH_R: begin
            // left neighbor arrives
            acc_ctrl.add = 1'b1;
            rd_addr  = {row_ff, col_ff + 5'd1};
            state_in = ST_FETCH_U;
         end
         ST_FETCH_U: begin
            acc_ctrl.add = 1'b1;
            rd_addr  = {row_ff - 5'd1, col_ff};
            state_in = ST_FETCH_D;
         end
         ST_FETCH_D: begin
            acc_ctrl.add = 1'b1;
            rd_addr  = {row_ff + 5'd1, col_ff};
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            // lower neighbor arrives: last term
            acc_ctrl.add = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // write the new value in place and advance, rows inner
            grid_we = 1'b1;
            if (delta > change_ff) change_in = delta;
            if (row_ff + 5'd1 < n_ff) begin
               row_in   = row_ff + 5'd1;
               state_in = ST_FETCH_C;
            end else if (col_ff + 5'd1 < n_ff) begin
               row_in   = 5'd1;
               col_in   = col_ff + 5'd1;
               state_in = ST_FETCH_C;
            end else begin
               state_in = ST_SWEEP_END;
            end
         end
         ST_SWEEP_END: begin
            sweeps_in      = sweeps_ff + 16'd1;
            stat_sweeps_in = sweeps_ff + 16'd1;
            stat_change_in = change_ff;
            if (change_ff < thresh_ff) begin
               stat_conv_in = 1'b1;
               state_in     = ST_RESULT;
            end else if (sweeps_ff + 16'd1 == max_sweeps_ff) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_SWEEP_START;
            end
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = is_read_ff ? grid_rdata_ff : '0;
               rsp_sweeps_in = stat_sweeps_ff;
               rsp_change_in = stat_change_ff;
               rsp_conv_in   = stat_conv_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         stat_sweeps_ff <= '0;
         stat_change_ff <= '0;
         stat_conv_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         stat_sweeps_ff <= stat_sweeps_in;
         stat_change_ff <= stat_change_in;
         stat_conv_ff   <= stat_conv_in;
      end
      row_ff        <= row_in;
      col_ff        <= col_in;
      n_ff          <= n_in;
      sweeps_ff     <= sweeps_in;
      change_ff     <= change_in;
      old_ff        <= old_in;
      is_read_ff    <= is_read_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_sweeps_ff <= rsp_sweeps_in;
      rsp_change_ff <= rsp_change_in;
      rsp_conv_ff   <= rsp_conv_in;
   end

   assign rsp.rsp_valid       = rsp_valid_ff;
   assign rsp.rsp_value_out   = rsp_value_ff;
   assign rsp.rsp_sweeps_done = rsp_sweeps_ff;
   assign rsp.rsp_last_change = rsp_change_ff;
   assign rsp.rsp_converged   = rsp_conv_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.rsp_ready |=> rsp_valid_ff)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.rsp_ready |=> $stable(rsp_value_ff) && $stable(rsp_sweeps_ff)
         && $stable(rsp_change_ff) && $stable(rsp_conv_ff))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.req_ready)
      else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP_END && change_ff < thresh_ff |=> stat_conv_ff)
      else $error("converged flag missed");
endmodule
